/* sv/issa_pkg.sv */
// Shared types and constants for the interval stack slot allocator.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package issa_pkg;

  localparam int unsigned DEF_MAX_SLOTS = 32;

  localparam int unsigned START_W  = 16;
  localparam int unsigned END_W    = 17;
  localparam int unsigned SIZE_W   = 8;
  localparam int unsigned FRAME_W  = 20;
  localparam int unsigned IDX_OUT_W = 5;

  localparam logic [FRAME_W-1:0] FRAME_MAX = {FRAME_W{1'b1}};

  typedef logic [FRAME_W-1:0]        frame_t;
  typedef logic signed [END_W-1:0]   point_t;
  typedef logic [START_W-1:0]        start_t;
  typedef logic [SIZE_W-1:0]         size_t;
  typedef logic [IDX_OUT_W-1:0]      idx_out_t;

  // Write controls and data from the sequencer to the slot store
  typedef struct packed {
    logic   free_en;
    logic   base_en;
    point_t free_at;
    frame_t base;
  } slot_wr_t;

endpackage

/* sv/issa_slot_mem.sv */
// Slot store: free-at point and frame offset of each slot.
// One write port, one registered read port. Depends on issa_pkg.
`timescale 1ns / 1ps

module issa_slot_mem #(
  parameter int unsigned MAX_SLOTS = issa_pkg::DEF_MAX_SLOTS,
  parameter int unsigned SLOT_W    = $clog2(MAX_SLOTS)
) (
  input  logic                  clk,
  input  issa_pkg::slot_wr_t    wr,
  input  logic [SLOT_W-1:0]     waddr,
  input  logic                  re,
  input  logic [SLOT_W-1:0]     raddr,
  output issa_pkg::point_t      rd_free_at,
  output issa_pkg::frame_t      rd_base
);
  import issa_pkg::*;

  point_t free_mem [MAX_SLOTS];
  frame_t base_mem [MAX_SLOTS];

  // Write both arrays at one address
  always_ff @(posedge clk) begin
    if (wr.free_en) begin
      free_mem[waddr] <= wr.free_at;
    end
    if (wr.base_en) begin
      base_mem[waddr] <= wr.base;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    if (re) begin
      rd_free_at <= free_mem[raddr];
      rd_base    <= base_mem[raddr];
    end
  end

endmodule

/* sv/issa_seq.sv */
// Scan sequencer: one slot compared per cycle, then allocate and report.
// Depends on issa_pkg; drives issa_slot_mem.
`timescale 1ns / 1ps

module issa_seq #(
  parameter int unsigned MAX_SLOTS = issa_pkg::DEF_MAX_SLOTS,
  parameter int unsigned SLOT_W    = $clog2(MAX_SLOTS),
  parameter int unsigned CNT_W     = $clog2(MAX_SLOTS + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  issa_pkg::start_t      start_point,
  input  issa_pkg::point_t      end_point,
  input  issa_pkg::size_t       value_size,
  input  logic                  first_item,
  input  logic                  last_item,
  input  issa_pkg::frame_t      base_frame,
  // slot store
  output issa_pkg::slot_wr_t    wr,
  output logic [SLOT_W-1:0]     waddr,
  output logic                  re,
  output logic [SLOT_W-1:0]     raddr,
  input  issa_pkg::point_t      rd_free_at,
  input  issa_pkg::frame_t      rd_base,
  // result
  output logic                  res_valid,
  output issa_pkg::idx_out_t    res_slot_index,
  output issa_pkg::frame_t      res_slot_offset,
  output logic                  res_opened_new,
  output issa_pkg::frame_t      res_frame_total,
  output logic                  res_overflow,
  output logic                  res_last
);
  import issa_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_ALLOC} state_t;

  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_SLOTS);

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  frame_t            frame_r, frame_nxt;
  logic [CNT_W-1:0]  scan_j_r, scan_j_nxt;
  logic              pend_r, pend_nxt;
  logic [SLOT_W-1:0] pend_idx_r, pend_idx_nxt;
  start_t            start_r, start_nxt;
  point_t            end_r, end_nxt;
  size_t             size_r, size_nxt;
  logic              last_r, last_nxt;

  logic              valid_r, valid_nxt;
  idx_out_t          idx_r, idx_nxt;
  frame_t            off_r, off_nxt;
  logic              opened_r, opened_nxt;
  frame_t            fsize_r, fsize_nxt;
  logic              over_r, over_nxt;
  logic              rlast_r, rlast_nxt;

  logic              match;
  logic [FRAME_W:0]  grown;

  // Single compare unit: slot free at or before the start point
  assign match = pend_r && (rd_free_at <= $signed({1'b0, start_r}));
  assign grown = {1'b0, frame_r} + {{(FRAME_W+1-SIZE_W){1'b0}}, size_r};

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    frame_nxt    = frame_r;
    scan_j_nxt   = scan_j_r;
    pend_nxt     = pend_r;
    pend_idx_nxt = pend_idx_r;
    start_nxt    = start_r;
    end_nxt      = end_r;
    size_nxt     = size_r;
    last_nxt     = last_r;
    valid_nxt    = 1'b0;
    idx_nxt      = idx_r;
    off_nxt      = off_r;
    opened_nxt   = opened_r;
    fsize_nxt    = fsize_r;
    over_nxt     = over_r;
    rlast_nxt    = rlast_r;
    wr           = '{free_en: 1'b0, base_en: 1'b0, free_at: end_r, base: frame_r};
    waddr        = pend_idx_r;
    re           = 1'b0;
    raddr        = scan_j_r[SLOT_W-1:0];

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          start_nxt  = start_point;
          end_nxt    = end_point;
          size_nxt   = value_size;
          last_nxt   = last_item;
          scan_j_nxt = '0;
          pend_nxt   = 1'b0;
          if (first_item) begin
            count_nxt = '0;
            frame_nxt = base_frame;
          end
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (match) begin
          // Reuse the pending slot
          wr.free_en = 1'b1;
          valid_nxt  = 1'b1;
          idx_nxt    = IDX_OUT_W'(pend_idx_r);
          off_nxt    = rd_base;
          opened_nxt = 1'b0;
          fsize_nxt  = frame_r;
          over_nxt   = 1'b0;
          rlast_nxt  = last_r;
          pend_nxt   = 1'b0;
          state_nxt  = ST_IDLE;
        end else if (scan_j_r < count_r) begin
          // Issue the next slot read
          re           = 1'b1;
          pend_nxt     = 1'b1;
          pend_idx_nxt = scan_j_r[SLOT_W-1:0];
          scan_j_nxt   = scan_j_r + 1'b1;
        end else begin
          // Drain the last compare, then allocate
          pend_nxt = 1'b0;
          if (!pend_r) begin
            state_nxt = ST_ALLOC;
          end
        end
      end
      ST_ALLOC: begin
        valid_nxt = 1'b1;
        rlast_nxt = last_r;
        if (count_r == FULL_CNT) begin
          idx_nxt    = '0;
          off_nxt    = '0;
          opened_nxt = 1'b0;
          over_nxt   = 1'b1;
          fsize_nxt  = frame_r;
        end else begin
          // Open a new slot at the current frame size
          wr.free_en = 1'b1;
          wr.base_en = 1'b1;
          waddr      = count_r[SLOT_W-1:0];
          idx_nxt    = IDX_OUT_W'(count_r);
          off_nxt    = frame_r;
          opened_nxt = 1'b1;
          over_nxt   = 1'b0;
          frame_nxt  = grown[FRAME_W] ? FRAME_MAX : grown[FRAME_W-1:0];
          fsize_nxt  = frame_nxt;
          count_nxt  = count_r + 1'b1;
        end
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Hold state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      frame_r <= '0;
      pend_r  <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      frame_r <= frame_nxt;
      pend_r  <= pend_nxt;
      valid_r <= valid_nxt;
    end
    scan_j_r   <= scan_j_nxt;
    pend_idx_r <= pend_idx_nxt;
    start_r    <= start_nxt;
    end_r      <= end_nxt;
    size_r     <= size_nxt;
    last_r     <= last_nxt;
    idx_r      <= idx_nxt;
    off_r      <= off_nxt;
    opened_r   <= opened_nxt;
    fsize_r    <= fsize_nxt;
    over_r     <= over_nxt;
    rlast_r    <= rlast_nxt;
  end

  assign busy            = (state_r != ST_IDLE);
  assign res_valid       = valid_r;
  assign res_slot_index  = idx_r;
  assign res_slot_offset = off_r;
  assign res_opened_new  = opened_r;
  assign res_frame_total = fsize_r;
  assign res_overflow    = over_r;
  assign res_last        = rlast_r;

endmodule

/* sv/interval_stack_slot_allocator.sv */
// Interval stack slot allocator, first-fit linear scan over the slots in use.
// A reused slot is reported as soon as its compare matches; otherwise every slot in use is scanned
// and a new slot is opened, or overflow is reported when the table is full.
// A new beat is taken only while idle, at the edge that ends the strobe of the previous result.
// Reset (rst_n low, synchronous): empty table, frame size 0, base register 0.
// Results are strobed for one cycle and cannot be stalled.
`timescale 1ns / 1ps

module interval_stack_slot_allocator #(
  parameter int unsigned MAX_SLOTS = issa_pkg::DEF_MAX_SLOTS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  issa_pkg::start_t      in_start_point,
  input  issa_pkg::point_t      in_end_point,
  input  issa_pkg::size_t       in_value_size,
  input  logic                  in_first_item,
  input  logic                  in_last_item,
  output logic                  out_valid,
  output issa_pkg::idx_out_t    out_slot_index,
  output issa_pkg::frame_t      out_slot_offset,
  output logic                  out_opened_new,
  output issa_pkg::frame_t      out_frame_total,
  output logic                  out_overflow,
  output logic                  out_last_result,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  issa_pkg::frame_t      cfg_data
);
  import issa_pkg::*;

  localparam int unsigned SLOT_W = $clog2(MAX_SLOTS);

  frame_t            base_r;
  slot_wr_t          wr;
  logic [SLOT_W-1:0] waddr;
  logic              re;
  logic [SLOT_W-1:0] raddr;
  point_t            rd_free_at;
  frame_t            rd_base;

  // Base frame size register, written while idle
  assign cfg_ready = !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      base_r <= cfg_data;
    end
  end

  issa_seq #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_seq (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .start_point     (in_start_point),
    .end_point       (in_end_point),
    .value_size      (in_value_size),
    .first_item      (in_first_item),
    .last_item       (in_last_item),
    .base_frame      (base_r),
    .wr              (wr),
    .waddr           (waddr),
    .re              (re),
    .raddr           (raddr),
    .rd_free_at      (rd_free_at),
    .rd_base         (rd_base),
    .res_valid       (out_valid),
    .res_slot_index  (out_slot_index),
    .res_slot_offset (out_slot_offset),
    .res_opened_new  (out_opened_new),
    .res_frame_total (out_frame_total),
    .res_overflow    (out_overflow),
    .res_last        (out_last_result)
  );

  issa_slot_mem #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_mem (
    .clk        (clk),
    .wr         (wr),
    .waddr      (waddr),
    .re         (re),
    .raddr      (raddr),
    .rd_free_at (rd_free_at),
    .rd_base    (rd_base)
  );

endmodule

/* sv/issa_checker.sv */
// Port-level checks for the interval stack slot allocator, bound to the top level.
// Depends on issa_pkg and interval_stack_slot_allocator.
`timescale 1ns / 1ps

module issa_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_valid,
  input issa_pkg::idx_out_t out_slot_index,
  input issa_pkg::frame_t   out_slot_offset,
  input logic               out_opened_new,
  input logic               out_overflow
);
  import issa_pkg::*;

  // An accepted beat makes the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("block not busy after accepting a beat");

  // A result beat is a single-cycle strobe
  a_strobe_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  // The block is ready again while a result is shown
  a_idle_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("busy during result strobe");

  // Overflow allocates nothing
  a_overflow_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_overflow |->
      !out_opened_new && (out_slot_index == '0) && (out_slot_offset == '0))
    else $error("overflow result carries an allocation");

endmodule

bind interval_stack_slot_allocator issa_checker u_issa_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_slot_index  (out_slot_index),
  .out_slot_offset (out_slot_offset),
  .out_opened_new  (out_opened_new),
  .out_overflow    (out_overflow)
);

/* tb/sv/interval_stack_slot_allocator_tb.sv */
// Self-checking testbench for the interval stack slot allocator: directed lifetimes, then
// random well-formed runs with random noise, checked against a built-in first-fit predictor.
// Depends on issa_pkg and interval_stack_slot_allocator only.
`timescale 1ns / 1ps

module interval_stack_slot_allocator_tb;
  import issa_pkg::*;

  localparam int MAX_SLOTS   = int'(DEF_MAX_SLOTS);
  localparam int ITEM_TARGET = 500;
  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE      = MAX_SLOTS + 8;

  typedef struct packed {
    idx_out_t slot_index;
    frame_t   slot_offset;
    logic     opened_new;
    frame_t   frame_total;
    logic     overflow;
    logic     last_result;
  } placement_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     start = 1'b0;
  logic     busy;
  start_t   in_start_point = '0;
  point_t   in_end_point = '0;
  size_t    in_value_size = '0;
  logic     in_first_item = 1'b0;
  logic     in_last_item = 1'b0;
  logic     out_valid;
  idx_out_t out_slot_index;
  frame_t   out_slot_offset;
  logic     out_opened_new;
  frame_t   out_frame_total;
  logic     out_overflow;
  logic     out_last_result;
  logic     cfg_valid = 1'b0;
  logic     cfg_ready;
  frame_t   cfg_data = '0;

  // Predictor state
  point_t   free_at_mirror [MAX_SLOTS];
  frame_t   offset_mirror [MAX_SLOTS];
  int       slots_open = 0;
  frame_t   frame_now = '0;
  frame_t   base_setting = '0;

  placement_t placement_q[$];

  int mismatches = 0;
  int items_sent = 0;
  int base_writes = 0;
  int n_opened = 0;
  int n_reused = 0;
  int n_full = 0;
  int burst_left = 1;
  int idle_cycles = 0;

  interval_stack_slot_allocator #(.MAX_SLOTS(MAX_SLOTS)) u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_start_point  (in_start_point),
    .in_end_point    (in_end_point),
    .in_value_size   (in_value_size),
    .in_first_item   (in_first_item),
    .in_last_item    (in_last_item),
    .out_valid       (out_valid),
    .out_slot_index  (out_slot_index),
    .out_slot_offset (out_slot_offset),
    .out_opened_new  (out_opened_new),
    .out_frame_total (out_frame_total),
    .out_overflow    (out_overflow),
    .out_last_result (out_last_result),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data)
  );

  always #1 clk = ~clk;

  // Place one lifetime first-fit and advance the mirrored table
  function automatic placement_t place_lifetime(start_t s, point_t e, size_t sz,
                                                logic first, logic last);
    placement_t       r;
    logic [FRAME_W:0] grown;
    bit               found;
    r = '0;
    found = 1'b0;
    if (first) begin
      slots_open = 0;
      frame_now = base_setting;
    end
    for (int j = 0; j < slots_open; j++) begin
      if (!found && free_at_mirror[j] <= $signed({1'b0, s})) begin
        free_at_mirror[j] = e;
        r.slot_index = idx_out_t'(j);
        r.slot_offset = offset_mirror[j];
        found = 1'b1;
      end
    end
    if (!found) begin
      if (slots_open >= MAX_SLOTS) begin
        // table full: nothing changes
        r.overflow = 1'b1;
      end else begin
        grown = {1'b0, frame_now} + {{(FRAME_W+1-SIZE_W){1'b0}}, sz};
        r.slot_index = idx_out_t'(slots_open);
        r.slot_offset = frame_now;
        free_at_mirror[slots_open] = e;
        offset_mirror[slots_open] = frame_now;
        frame_now = grown[FRAME_W] ? FRAME_MAX : grown[FRAME_W-1:0];
        slots_open++;
        r.opened_new = 1'b1;
      end
    end
    r.frame_total = frame_now;
    r.last_result = last;
    return r;
  endfunction

  // Drive one lifetime, hold until accepted, then maybe take a gap
  task automatic send_lifetime(start_t s, point_t e, size_t sz, logic first, logic last);
    start <= 1'b1;
    in_start_point <= s;
    in_end_point <= e;
    in_value_size <= sz;
    in_first_item <= first;
    in_last_item <= last;
    do @(posedge clk); while (busy);
    placement_q.push_back(place_lifetime(s, e, sz, first, last));
    items_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
    end
  endtask

  // Drop start and wait until the block has nothing left in flight
  task automatic drain_and_settle();
    start <= 1'b0;
    while (placement_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Write the base frame size register; call only while idle
  task automatic write_base_frame(frame_t v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    base_setting = v;
    base_writes++;
  endtask

  function automatic frame_t pick_base();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return FRAME_MAX;
      2: return frame_t'($urandom_range(0, 4096));
      default: return frame_t'($urandom);
    endcase
  endfunction

  // Reuse of freed slots, never-used values, and items with no first item after reset
  task automatic test_reuse_and_unused();
    send_lifetime(16'd5, 17'sd10, 8'd8, 1'b0, 1'b0);
    send_lifetime(16'd10, -17'sd1, 8'd0, 1'b0, 1'b0);
    send_lifetime(16'd0, 17'sd65535, 8'd255, 1'b0, 1'b0);
    send_lifetime(16'd1, 17'sd3, 8'd4, 1'b0, 1'b1);
    send_lifetime(16'd0, -17'sd1, 8'd0, 1'b1, 1'b0);
    send_lifetime(16'd0, 17'sd0, 8'd0, 1'b0, 1'b0);
    send_lifetime(16'd0, 17'sd1, 8'd1, 1'b1, 1'b1);
    drain_and_settle();
  endtask

  // Frame growth past the top of the range saturates
  task automatic test_frame_saturation();
    write_base_frame(FRAME_MAX - 20'd300);
    send_lifetime(16'd0, 17'sd2, 8'd255, 1'b1, 1'b0);
    send_lifetime(16'd1, 17'sd4, 8'd255, 1'b0, 1'b0);
    send_lifetime(16'd2, 17'sd5, 8'd255, 1'b0, 1'b0);
    send_lifetime(16'd3, 17'sd65535, 8'd0, 1'b0, 1'b1);
    drain_and_settle();
    write_base_frame(FRAME_MAX);
    send_lifetime(16'd65535, 17'sd65535, 8'd255, 1'b1, 1'b1);
    drain_and_settle();
  endtask

  // Fill every slot with long lifetimes, overflow, then free the first slot
  task automatic test_table_full();
    int cur;
    cur = 0;
    write_base_frame(frame_t'($urandom_range(0, 1000)));
    for (int i = 0; i < MAX_SLOTS + 3; i++) begin
      send_lifetime(start_t'(cur), point_t'($urandom_range(60000, 65535)),
                    size_t'($urandom), i == 0, 1'b0);
      cur += $urandom_range(0, 100);
    end
    send_lifetime(16'd65535, 17'sd65535, size_t'($urandom), 1'b0, 1'b1);
    drain_and_settle();
  endtask

  // Mostly well-formed runs with random content, some random noise
  task automatic test_random_runs();
    int  len, cur, e, span, step;
    bit  crowd, fresh;
    while (items_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 3) == 0) begin
        drain_and_settle();
        write_base_frame(pick_base());
      end
      if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(1, 6)) begin
          e = ($urandom_range(0, 5) == 0) ? -1 : int'($urandom_range(0, 65535));
          send_lifetime(start_t'($urandom), point_t'(e), size_t'($urandom),
                        logic'($urandom_range(0, 1)), logic'($urandom_range(0, 1)));
        end
      end else begin
        crowd = ($urandom_range(0, 5) == 0);
        fresh = ($urandom_range(0, 9) != 0);
        len = $urandom_range(1, 40);
        span = crowd ? 65535 : $urandom_range(1, 300);
        step = crowd ? $urandom_range(0, 3) : $urandom_range(0, 12);
        cur = crowd ? $urandom_range(0, 2000) : $urandom_range(0, 65000);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(0, 9) == 0) begin
            e = -1;
          end else begin
            e = cur + int'($urandom_range(0, span));
            if (e > 65535) e = 65535;
          end
          send_lifetime(start_t'(cur), point_t'(e), size_t'($urandom),
                        fresh && i == 0, i == len - 1);
          cur += int'($urandom_range(0, step));
          if (cur > 65535) cur = 65535;
        end
      end
    end
    drain_and_settle();
  endtask

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Compare each result beat with the oldest pending placement
  always @(posedge clk) begin : check_results
    placement_t want;
    if (rst_n && out_valid) begin
      if (placement_q.size() == 0) begin
        $error("result beat with no placement pending");
        mismatches++;
      end else begin
        want = placement_q.pop_front();
        check_field("slot_index", want.slot_index, out_slot_index);
        check_field("slot_offset", want.slot_offset, out_slot_offset);
        check_field("opened_new", want.opened_new, out_opened_new);
        check_field("frame_total", want.frame_total, out_frame_total);
        check_field("overflow", want.overflow, out_overflow);
        check_field("last_result", want.last_result, out_last_result);
        if (want.overflow) n_full++;
        else if (want.opened_new) n_opened++;
        else n_reused++;
      end
    end
  end

  // Count cycles with no accepted beat on any port
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $error("no beat accepted for %0d cycles", STALL_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reuse_and_unused();
    test_frame_saturation();
    test_table_full();
    test_random_runs();
    $display("Placed %0d lifetimes over %0d base-frame settings.", items_sent, base_writes);
    $display("Slots opened %0d, reused %0d, table-full results %0d.",
             n_opened, n_reused, n_full);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* interval_stack_slot_allocator.f */
sv/issa_pkg.sv
sv/issa_slot_mem.sv
sv/issa_seq.sv
sv/interval_stack_slot_allocator.sv
sv/issa_checker.sv
tb/sv/interval_stack_slot_allocator_tb.sv
